FILE: hw/rtl/hgr_pkg.sv
`timescale 1ns / 1ps

package hgr_pkg;

  localparam int unsigned KeyInputs  = 4;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned PosW       = 16;
  localparam int unsigned ColW       = 3;
  localparam int unsigned MaxKeyCols = 4;
  localparam int unsigned GroupNumW  = 9;
  localparam int unsigned RankW      = 9;
  localparam int unsigned HashW      = 32;
  localparam int unsigned EpochW     = 8;

  localparam logic [RankW-1:0] RankMax  = 9'd511;
  localparam logic [HashW-1:0] MixMult  = 32'd2654435761;
  localparam logic [HashW-1:0] ColMult  = 32'd97;

  typedef logic [KeyInputs-1:0][KeyW-1:0] key_vec_t;

  typedef struct packed {
    logic            first;
    logic [PosW-1:0] pos;
    key_vec_t        key;
    logic [ColW-1:0] ncol;
  } row_t;

  typedef struct packed {
    row_t             row;
    logic [HashW-1:0] h;
    logic [HashW-1:0] m;
  } hbeat_t;

  typedef enum logic [2:0] {
    P_CLEAR,
    P_IDLE,
    P_READ,
    P_CHECK,
    P_GRP,
    P_RANK
  } probe_state_e;

endpackage

FILE: hw/rtl/hgr_if.sv
`timescale 1ns / 1ps

interface hgr_row_if import hgr_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   first_of_set;
  logic [PosW-1:0]        row_position;
  logic signed [KeyW-1:0] key_col0;
  logic signed [KeyW-1:0] key_col1;
  logic signed [KeyW-1:0] key_col2;
  logic signed [KeyW-1:0] key_col3;

  modport source (
    output valid, first_of_set, row_position, key_col0, key_col1, key_col2, key_col3,
    input  ready
  );

  modport sink (
    input  valid, first_of_set, row_position, key_col0, key_col1, key_col2, key_col3,
    output ready
  );
endinterface

interface hgr_res_if import hgr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PosW-1:0]      row_out;
  logic [GroupNumW-1:0] group_number;
  logic [RankW-1:0]     rank_in_group;
  logic                 new_group;
  logic                 table_full;

  modport source (
    output valid, row_out, group_number, rank_in_group, new_group, table_full,
    input  ready
  );

  modport sink (
    input  valid, row_out, group_number, rank_in_group, new_group, table_full,
    output ready
  );
endinterface

FILE: hw/rtl/hash_group_by_rows.sv
// Streaming group-by for rows of up to four signed 32-bit key columns. Each row beat
// returns one result beat with the row position, its dense group number in order of first
// appearance within the current set, its rank within that group, and flags for a newly
// opened group or a full table. A row first passes a chain of hash cells, two stages per key
// column, and a four-stage final mix; rows follow each other through that chain one per
// cycle while the prober takes them, else the whole chain stalls. The prober handles one
// row at a time on the single-port slot memory: a new group passes P_READ and P_CHECK, a
// key found at its home slot also P_GRP and P_RANK, and each further slot probed another
// P_READ and P_CHECK. After reset, and on the start of every 255th set, a clearing pass
// writes every slot and takes no row. The user must write the active column count through
// cfg_we_i only while idle, which is not enforced; zero reads as one, above four as four.
`timescale 1ns / 1ps

module hash_group_by_rows import hgr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned MAX_GROUPS  = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ColW-1:0] cfg_wdata_i,
  hgr_row_if.sink         rows_i,
  hgr_res_if.source       res_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);

  logic [ColW-1:0]    act_q;
  logic [ColW-1:0]    ncol;
  row_t               in_row;
  hbeat_t             beat [KeyInputs+1];
  logic [KeyInputs:0] vld;
  logic               en, take, hv;
  row_t               hrow;
  logic [IW-1:0]      hidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ColW'(1);
    end else if (cfg_we_i) begin
      act_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    ncol = act_q;
    if (ncol == '0) begin
      ncol = ColW'(1);
    end
    if (ncol > ColW'(MaxKeyCols)) begin
      ncol = ColW'(MaxKeyCols);
    end
    if (ncol > ColW'(KeyInputs)) begin
      ncol = ColW'(KeyInputs);
    end
  end

  always_comb begin
    in_row.first  = rows_i.first_of_set;
    in_row.pos    = rows_i.row_position;
    in_row.key[0] = rows_i.key_col0;
    in_row.key[1] = rows_i.key_col1;
    in_row.key[2] = rows_i.key_col2;
    in_row.key[3] = rows_i.key_col3;
    in_row.ncol   = ncol;
  end

  assign en           = !hv || take;
  assign rows_i.ready = en;
  assign vld[0]       = rows_i.valid;
  assign beat[0]      = '{row: in_row, h: '0, m: '0};

  for (genvar i = 0; i < KeyInputs; i++) begin : g_cell
    hgr_cell #(
      .Col (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[i]),
      .beat_i (beat[i]),
      .vld_o  (vld[i+1]),
      .beat_o (beat[i+1])
    );
  end

  hgr_mix #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld[KeyInputs]),
    .beat_i (beat[KeyInputs]),
    .vld_o  (hv),
    .row_o  (hrow),
    .idx_o  (hidx)
  );

  hgr_probe #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_GROUPS  (MAX_GROUPS)
  ) u_probe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hv_i   (hv),
    .hrow_i (hrow),
    .hidx_i (hidx),
    .take_o (take),
    .res_o  (res_o)
  );

endmodule

FILE: hw/rtl/hgr_cell.sv
`timescale 1ns / 1ps

module hgr_cell import hgr_pkg::*; #(
  parameter int unsigned Col = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   vld_i,
  input  hbeat_t beat_i,
  output logic   vld_o,
  output hbeat_t beat_o
);

  localparam logic [HashW-1:0] Coef = HashW'(ColMult * (Col + 1));

  logic   a_vld_q, b_vld_q;
  hbeat_t a_d, a_q, b_d, b_q;

  always_comb begin
    a_d   = beat_i;
    a_d.m = HashW'(beat_i.row.key[Col] * MixMult);
  end

  always_comb begin
    b_d = a_q;
    if (ColW'(Col) < a_q.row.ncol) begin
      b_d.h = a_q.h ^ HashW'(a_q.m * Coef);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign beat_o = b_q;

endmodule

FILE: hw/rtl/hgr_mix.sv
`timescale 1ns / 1ps

module hgr_mix import hgr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  hbeat_t                         beat_i,
  output logic                           vld_o,
  output row_t                           row_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned K  = HashW + IW;
  localparam logic [63:0] Pow   = 64'd1 << K;
  localparam logic [63:0] Recip = (Pow + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);

  logic [3:0]       vld_q;
  row_t             r1_q, r2_q, r3_q, r4_q;
  logic [HashW-1:0] x1_q, x2_q, x3_q, q3_q;
  logic [IW-1:0]    idx_q;
  logic [HashW-1:0] f1, f2, rem;
  logic [64:0]      prod;

  assign f1   = beat_i.h ^ (beat_i.h >> 16);
  assign f2   = x1_q ^ (x1_q >> 15);
  assign prod = {33'd0, x2_q} * {32'd0, Recip[32:0]};
  assign rem  = x3_q - HashW'(q3_q * HashW'(TABLE_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q  <= beat_i.row;
      x1_q  <= HashW'(f1 * MixMult);
      r2_q  <= r1_q;
      x2_q  <= f2;
      r3_q  <= r2_q;
      x3_q  <= x2_q;
      q3_q  <= HashW'(prod[64:K]);
      r4_q  <= r3_q;
      idx_q <= rem[IW-1:0];
    end
  end

  assign vld_o = vld_q[3];
  assign row_o = r4_q;
  assign idx_o = idx_q;

endmodule

FILE: hw/rtl/hgr_probe.sv
`timescale 1ns / 1ps

module hgr_probe import hgr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned MAX_GROUPS  = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           hv_i,
  input  row_t                           hrow_i,
  input  logic [$clog2(TABLE_SLOTS)-1:0] hidx_i,
  output logic                           take_o,
  hgr_res_if.source                      res_o
);

  localparam int unsigned IW  = $clog2(TABLE_SLOTS);
  localparam int unsigned GW  = $clog2(MAX_GROUPS);
  localparam int unsigned GNW = $clog2(MAX_GROUPS + 1);
  localparam logic [IW-1:0]  LastIdx    = IW'(TABLE_SLOTS - 1);
  localparam logic [GNW-1:0] GroupLimit = GNW'(MAX_GROUPS);

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    key_vec_t          key;
    logic [GW-1:0]     grp;
  } slot_t;

  slot_t            slot_mem [TABLE_SLOTS];
  logic [RankW-1:0] memb_mem [MAX_GROUPS];

  probe_state_e      st_d, st_q;
  row_t              row_d, row_q;
  logic [IW-1:0]     idx_d, idx_q, probes_d, probes_q, clr_d, clr_q;
  logic              pend_d, pend_q;
  logic [EpochW-1:0] epoch_d, epoch_q;
  logic [GNW-1:0]    groups_d, groups_q;
  logic [GW-1:0]     g_d, g_q;
  slot_t             slot_rd_q;
  logic [RankW-1:0]  mrd_q;

  logic              sw_en, sr_en, mw_en, mr_en;
  logic [IW-1:0]     sw_addr;
  slot_t             sw_data;
  logic [GW-1:0]     mw_addr;
  logic [RankW-1:0]  mw_data;

  logic                 res_load, res_new, res_full;
  logic [GroupNumW-1:0] res_grp;
  logic [RankW-1:0]     res_rank;
  logic                 out_vld_q, new_q, full_q;
  logic [PosW-1:0]      pos_q;
  logic [GroupNumW-1:0] grp_q;
  logic [RankW-1:0]     rank_q;

  logic out_free, hit_valid, key_eq, groups_full, last_probe, wrap_epoch;

  assign out_free    = !out_vld_q || res_o.ready;
  assign hit_valid   = slot_rd_q.epoch == epoch_q;
  assign groups_full = groups_q >= GroupLimit;
  assign last_probe  = probes_q == LastIdx;
  assign wrap_epoch  = epoch_q == {EpochW{1'b1}};

  always_comb begin
    key_eq = 1'b1;
    for (int j = 0; j < KeyInputs; j++) begin
      if ((ColW'(j) < row_q.ncol) && (slot_rd_q.key[j] != row_q.key[j])) begin
        key_eq = 1'b0;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      P_CLEAR: begin
        if (clr_q == LastIdx) begin
          st_d = pend_q ? P_READ : P_IDLE;
        end
      end
      P_IDLE: begin
        if (hv_i) begin
          st_d = (hrow_i.first && wrap_epoch) ? P_CLEAR : P_READ;
        end
      end
      P_READ:  st_d = P_CHECK;
      P_CHECK: begin
        if (!hit_valid || (!key_eq && last_probe)) begin
          if (out_free) begin
            st_d = P_IDLE;
          end
        end else if (key_eq) begin
          st_d = P_GRP;
        end else begin
          st_d = P_READ;
        end
      end
      P_GRP: st_d = P_RANK;
      P_RANK: begin
        if (out_free) begin
          st_d = P_IDLE;
        end
      end
      default: st_d = P_IDLE;
    endcase
  end

  always_comb begin
    take_o   = 1'b0;
    sw_en    = 1'b0;
    sw_addr  = idx_q;
    sw_data  = '0;
    sr_en    = 1'b0;
    mw_en    = 1'b0;
    mw_addr  = groups_q[GW-1:0];
    mw_data  = RankW'(1);
    mr_en    = 1'b0;
    res_load = 1'b0;
    res_grp  = '0;
    res_rank = '0;
    res_new  = 1'b0;
    res_full = 1'b0;
    row_d    = row_q;
    idx_d    = idx_q;
    probes_d = probes_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    epoch_d  = epoch_q;
    groups_d = groups_q;
    g_d      = g_q;
    unique case (st_q)
      P_CLEAR: begin
        sw_en   = 1'b1;
        sw_addr = clr_q;
        if (clr_q == LastIdx) begin
          clr_d  = '0;
          pend_d = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      P_IDLE: begin
        take_o = hv_i;
        if (hv_i) begin
          row_d    = hrow_i;
          idx_d    = hidx_i;
          probes_d = '0;
          if (hrow_i.first) begin
            groups_d = '0;
            if (wrap_epoch) begin
              epoch_d = EpochW'(1);
              pend_d  = 1'b1;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end
        end
      end
      P_READ: sr_en = 1'b1;
      P_CHECK: begin
        if (!hit_valid) begin
          if (out_free) begin
            res_load = 1'b1;
            if (groups_full) begin
              res_full = 1'b1;
            end else begin
              sw_en    = 1'b1;
              sw_data  = '{epoch: epoch_q, key: row_q.key, grp: groups_q[GW-1:0]};
              mw_en    = 1'b1;
              res_grp  = GroupNumW'(groups_q[GW-1:0]);
              res_new  = 1'b1;
              groups_d = GNW'(groups_q + 1'b1);
            end
          end
        end else if (key_eq) begin
          g_d = slot_rd_q.grp;
        end else if (last_probe) begin
          if (out_free) begin
            res_load = 1'b1;
            res_full = 1'b1;
          end
        end else begin
          idx_d    = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
          probes_d = probes_q + 1'b1;
        end
      end
      P_GRP: mr_en = 1'b1;
      P_RANK: begin
        if (out_free) begin
          res_load = 1'b1;
          res_grp  = GroupNumW'(g_q);
          res_rank = mrd_q;
          mw_en    = 1'b1;
          mw_addr  = g_q;
          mw_data  = (mrd_q < RankMax) ? RankW'(mrd_q + 1'b1) : mrd_q;
        end
      end
      default: take_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= P_CLEAR;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      epoch_q   <= EpochW'(1);
      groups_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      epoch_q   <= epoch_d;
      groups_q  <= groups_d;
      out_vld_q <= res_load | (out_vld_q & !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    idx_q    <= idx_d;
    probes_q <= probes_d;
    g_q      <= g_d;
    if (res_load) begin
      pos_q  <= row_q.pos;
      grp_q  <= res_grp;
      rank_q <= res_rank;
      new_q  <= res_new;
      full_q <= res_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      slot_mem[sw_addr] <= sw_data;
    end
    if (sr_en) begin
      slot_rd_q <= slot_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      memb_mem[mw_addr] <= mw_data;
    end
    if (mr_en) begin
      mrd_q <= memb_mem[g_q];
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.row_out       = pos_q;
  assign res_o.group_number  = grp_q;
  assign res_o.rank_in_group = rank_q;
  assign res_o.new_group     = new_q;
  assign res_o.table_full    = full_q;

endmodule

FILE: hw/rtl/hgr_checker.sv
`timescale 1ns / 1ps

module hgr_checker import hgr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [PosW-1:0]      out_row_i,
  input logic [GroupNumW-1:0] out_group_i,
  input logic [RankW-1:0]     out_rank_i,
  input logic                 out_new_i,
  input logic                 out_full_i
);

  logic [16:0] cnt_d, cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && in_ready_i) begin
      cnt_d = cnt_d + 1'b1;
    end
    if (out_valid_i && out_ready_i) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result beat dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_group_i)
      && $stable(out_rank_i) && $stable(out_new_i) && $stable(out_full_i))
    else $error("Result beat changed while stalled.");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_full_i |-> out_group_i == '0 && out_rank_i == '0 && !out_new_i)
    else $error("Full-table result carries group fields.");

  a_new_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_new_i |-> out_rank_i == '0 && !out_full_i)
    else $error("New group result with nonzero rank.");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("Result beat without an outstanding row.");

endmodule

bind hash_group_by_rows hgr_checker u_hgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rows_i.valid),
  .in_ready_i  (rows_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_row_i   (res_o.row_out),
  .out_group_i (res_o.group_number),
  .out_rank_i  (res_o.rank_in_group),
  .out_new_i   (res_o.new_group),
  .out_full_i  (res_o.table_full)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hgr_pkg::*;

  localparam int unsigned TableSlots   = 1024;
  localparam int unsigned GroupLimit   = 512;
  localparam int unsigned RankCeiling  = 511;
  localparam int unsigned ColsPerRow   = 4;
  localparam int unsigned PhaseRows    = 43;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned SettleCycles = 20;
  localparam bit [31:0]   Scramble     = 32'd2654435761;
  localparam bit [31:0]   ColumnWeight = 32'd97;
  localparam bit [31:0]   IntMin       = 32'h8000_0000;
  localparam bit [31:0]   IntMax       = 32'h7FFF_FFFF;
  localparam bit [31:0]   AllOnes      = 32'hFFFF_FFFF;

  typedef bit [KeyInputs-1:0][KeyW-1:0] key_t;

  typedef struct packed {
    bit            first;
    bit [PosW-1:0] pos;
    key_t          key;
  } row_item_t;

  typedef struct packed {
    bit [PosW-1:0]      pos;
    bit [GroupNumW-1:0] grp;
    bit [RankW-1:0]     rank;
    bit                 opened;
    bit                 full;
  } label_t;

  class label_tracker;
    bit [ColW-1:0] column_reg = 3'd1;
    bit            slot_used  [TableSlots];
    key_t          slot_key   [TableSlots];
    int unsigned   slot_owner [TableSlots];
    int unsigned   members    [GroupLimit];
    int unsigned   group_count;
    label_t        expected_labels [$];
    int unsigned   mismatches;
    int unsigned   rows_seen;
    int unsigned   sets_seen;
    int unsigned   groups_opened;
    int unsigned   limit_hits;
    bit [7:0]      settings_used;

    function void set_columns(bit [ColW-1:0] value);
      column_reg = value;
      settings_used[value] = 1'b1;
    endfunction

    function int unsigned key_columns();
      int unsigned n;
      n = column_reg;
      if (n == 0) n = 1;
      if (n > MaxKeyCols) n = MaxKeyCols;
      if (n > ColsPerRow) n = ColsPerRow;
      return n;
    endfunction

    function int unsigned home_slot(key_t key, int unsigned n);
      bit [31:0] h;
      bit [31:0] m;
      h = '0;
      for (int unsigned j = 0; j < n; j++) begin
        m = key[j] * Scramble;
        h ^= m * ColumnWeight * (j + 1);
      end
      h ^= h >> 16;
      h = h * Scramble;
      h ^= h >> 15;
      return h % TableSlots;
    endfunction

    function label_t label_row(row_item_t r);
      label_t      lbl;
      int unsigned n;
      int unsigned idx;
      int unsigned g;
      bit          hit;
      lbl = '0;
      lbl.pos = r.pos;
      if (r.first) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        group_count = 0;
        sets_seen++;
      end
      n = key_columns();
      idx = home_slot(r.key, n);
      for (int unsigned probe = 0; probe < TableSlots; probe++) begin
        if (!slot_used[idx]) begin
          if (group_count >= GroupLimit) break;
          g = group_count;
          group_count++;
          slot_used[idx] = 1'b1;
          slot_key[idx] = r.key;
          slot_owner[idx] = g;
          members[g] = 1;
          lbl.grp = GroupNumW'(g);
          lbl.opened = 1'b1;
          groups_opened++;
          return lbl;
        end
        hit = 1'b1;
        for (int unsigned j = 0; j < n; j++) begin
          if (slot_key[idx][j] != r.key[j]) hit = 1'b0;
        end
        if (hit) begin
          g = slot_owner[idx] % GroupLimit;
          lbl.grp = GroupNumW'(g);
          lbl.rank = RankW'((members[g] > RankCeiling) ? RankCeiling : members[g]);
          if (members[g] < RankCeiling) members[g]++;
          return lbl;
        end
        idx = (idx + 1) % TableSlots;
      end
      lbl.full = 1'b1;
      limit_hits++;
      return lbl;
    endfunction

    function void log_row(row_item_t r);
      expected_labels.push_back(label_row(r));
      rows_seen++;
    endfunction

    task report(string what, int unsigned row, int unsigned want, int unsigned got);
      mismatches++;
      $display("[%0t] mismatch at row %0d: %s expected %0d, got %0d",
               $time, row, what, want, got);
    endtask

    task check_label(label_t got);
      label_t want;
      if (expected_labels.size() == 0) begin
        report("unexpected result beat", got.pos, 0, 1);
        return;
      end
      want = expected_labels.pop_front();
      if (got.pos != want.pos) report("row_out", want.pos, want.pos, got.pos);
      if (got.grp != want.grp) report("group_number", want.pos, want.grp, got.grp);
      if (got.rank != want.rank) report("rank_in_group", want.pos, want.rank, got.rank);
      if (got.opened != want.opened) report("new_group", want.pos, want.opened, got.opened);
      if (got.full != want.full) report("table_full", want.pos, want.full, got.full);
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ColW-1:0] cfg_wdata_i;

  hgr_row_if row_bus ();
  hgr_res_if res_bus ();

  hash_group_by_rows #(
    .TABLE_SLOTS(TableSlots),
    .MAX_GROUPS (GroupLimit)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rows_i     (row_bus),
    .res_o      (res_bus)
  );

  label_tracker  tracker = new();
  bit            idling_on = 1'b1;
  int unsigned   stall_request;
  key_t          key_pool [$];
  bit [ColW-1:0] phase_cols [NumPhases] = '{3'd2, 3'd4, 3'd1, 3'd3, 3'd6,
                                            3'd0, 3'd5, 3'd7, 3'd4, 3'd2};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return AllOnes;
      2: return IntMin;
      3: return IntMax;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_pool();
    key_t k;
    key_pool.delete();
    repeat ($urandom_range(3, 24)) begin
      for (int j = 0; j < ColsPerRow; j++) k[j] = pick_word();
      key_pool.push_back(k);
    end
  endfunction

  // Mostly keys from a small pool so groups recur; columns past the active count are
  // sometimes scrambled so only the compared prefix decides the group.
  function automatic row_item_t random_row(bit fresh);
    row_item_t   r;
    int unsigned roll;
    int unsigned n;
    n = tracker.key_columns();
    roll = $urandom_range(0, 99);
    r.first = fresh || ($urandom_range(0, 39) == 0);
    r.pos = PosW'($urandom);
    if (roll < 65) begin
      r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if ($urandom_range(0, 1) == 1) begin
        for (int j = n; j < ColsPerRow; j++) r.key[j] = pick_word();
      end
    end else if (roll < 80) begin
      r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      r.key[$urandom_range(0, ColsPerRow - 1)] = pick_word();
    end else begin
      for (int j = 0; j < ColsPerRow; j++) r.key[j] = pick_word();
    end
    return r;
  endfunction

  task automatic send_row(row_item_t r);
    row_bus.valid        <= 1'b1;
    row_bus.first_of_set <= r.first;
    row_bus.row_position <= r.pos;
    row_bus.key_col0     <= r.key[0];
    row_bus.key_col1     <= r.key[1];
    row_bus.key_col2     <= r.key[2];
    row_bus.key_col3     <= r.key[3];
    do @(posedge clk_i); while (row_bus.ready !== 1'b1);
    tracker.log_row(r);
  endtask

  task automatic rest();
    int unsigned gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap != 0) begin
      row_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer(bit first, bit [PosW-1:0] pos,
                       bit [31:0] k0, bit [31:0] k1, bit [31:0] k2, bit [31:0] k3);
    row_item_t r;
    r.first = first;
    r.pos = pos;
    r.key = {k3, k2, k1, k0};
    send_row(r);
    rest();
  endtask

  task automatic drain();
    row_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_labels.size() != 0);
  endtask

  task automatic write_columns(bit [ColW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_columns(value);
  endtask

  initial begin : result_sink
    label_t      got;
    int unsigned long_left;
    int unsigned short_left;
    long_left = 0;
    short_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got.pos    = res_bus.row_out;
        got.grp    = res_bus.group_number;
        got.rank   = res_bus.rank_in_group;
        got.opened = res_bus.new_group;
        got.full   = res_bus.table_full;
        tracker.check_label(got);
      end
      if (stall_request != 0) begin
        long_left = stall_request;
        stall_request = 0;
      end
      if (long_left != 0) begin
        long_left--;
        res_bus.ready <= 1'b0;
      end else if (short_left != 0) begin
        short_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if (idling_on) short_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((row_bus.valid === 1'b1 && row_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] no beat moved for %0d cycles", $time, QuietLimit);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    row_bus.valid        <= 1'b0;
    row_bus.first_of_set <= 1'b0;
    row_bus.row_position <= '0;
    row_bus.key_col0     <= '0;
    row_bus.key_col1     <= '0;
    row_bus.key_col2     <= '0;
    row_bus.key_col3     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One key column after reset.
    offer(1'b1, 16'd0,      '0,         '0,     '0,      '0);
    offer(1'b0, 16'hFFFF,   IntMin,     IntMax, AllOnes, '0);
    offer(1'b0, 16'd2,      IntMax,     '0,     '0,      '0);
    offer(1'b0, 16'd3,      '0,         AllOnes, AllOnes, AllOnes);
    offer(1'b0, 16'd4,      IntMin,     32'd5,  '0,      '0);
    offer(1'b0, 16'd5,      IntMin + 1, '0,     '0,      '0);
    offer(1'b0, 16'd6,      AllOnes,    '0,     '0,      '0);
    offer(1'b1, 16'd7,      AllOnes,    '0,     '0,      '0);
    drain();
    write_columns(3'd4);
    offer(1'b1, 16'd8,  32'd1,  32'd2,  32'd3,  32'd4);
    offer(1'b0, 16'd9,  32'd1,  32'd2,  32'd3,  32'd5);
    offer(1'b0, 16'd10, 32'd1,  32'd2,  32'd3,  32'd4);
    offer(1'b0, 16'd11, IntMin, IntMin, IntMin, IntMin);
    offer(1'b0, 16'd12, IntMax, IntMax, IntMax, IntMax);
    offer(1'b0, 16'd13, IntMin, IntMin, IntMin, IntMin);
    drain();
    // Zero reads as one column; the set carries over so stored keys are compared short.
    write_columns(3'd0);
    offer(1'b0, 16'd14, 32'd1,  32'd9, 32'd9, 32'd9);
    offer(1'b0, 16'd15, IntMin, '0,    '0,    '0);
    drain();
    write_columns(3'd7);
    offer(1'b0, 16'd16, 32'd1, 32'd9, 32'd9, 32'd9);
    offer(1'b0, 16'd17, 32'd1, 32'd2, 32'd3, 32'd4);
    drain();
    write_columns(3'd5);
    offer(1'b1, 16'd18, 32'd7, 32'd7, 32'd7, 32'd7);
    offer(1'b0, 16'd19, 32'd7, 32'd7, 32'd7, 32'd8);
    offer(1'b0, 16'd20, 32'd7, 32'd7, 32'd7, 32'd7);
    drain();
    write_columns(3'd3);
    offer(1'b0, 16'd21, 32'd7, 32'd7, 32'd7, 32'd9);
    offer(1'b0, 16'd22, 32'd7, 32'd7, 32'd7, 32'd7);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_columns(phase_cols[p]);
      idling_on = (p % 4 != 2) && (p != 3);
      build_pool();
      for (int i = 0; i < PhaseRows; i++) begin
        if (p == 3 && i == 5) stall_request = HoldCycles;
        if (p == 5 && i == PhaseRows / 2) drain();
        send_row(random_row(i == 0 && (p % 3 != 1)));
        rest();
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d rows over %0d sets: %0d groups opened, %0d rows refused at the limit.",
             tracker.rows_seen, tracker.sets_seen, tracker.groups_opened,
             tracker.limit_hits);
    $display("Column register values written (one bit per value): %b",
             tracker.settings_used);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
